// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is high.
`define PCBN_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pcbn assertion failed");

// Concurrent check that also runs during reset.
`define PCBN_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pcbn reset check failed");

`endif

// ----- rtl/pcbn_pkg.sv -----
// Shared types, constants and packing helpers for the box suppression block.
// No dependencies.
package pcbn_pkg;

  localparam int DEFAULT_MAX_BOXES = 64;
  localparam int QUEUE_DEPTH       = 4;
  localparam int DATA_W            = 88;
  localparam int THR_W             = 16;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd29491;

  typedef struct packed {
    logic [7:0]  cls;
    logic [15:0] score;
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] width;
    logic [15:0] height;
  } box_t;

  typedef struct packed {
    logic last;
    box_t box;
  } item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_INS_CHK, S_INS_RD, S_INS_CMP, S_INS_PUT, S_INIT,
    S_OUT_RD, S_OUT_CHK, S_IN_RD, S_IN_CHK, S_MUL, S_UNI, S_THR, S_CMP,
    S_FIND_RD, S_FIND_CHK, S_EM_RD, S_EM_CHK
  } state_t;

  // tdata layout, lowest bits first: class, score, left, top, width, height
  function automatic box_t unpack_box(logic [DATA_W-1:0] d);
    box_t b;
    b.cls    = d[7:0];
    b.score  = d[23:8];
    b.left   = d[39:24];
    b.top    = d[55:40];
    b.width  = d[71:56];
    b.height = d[87:72];
    return b;
  endfunction

  function automatic logic [DATA_W-1:0] pack_box(box_t b);
    return {b.height, b.width, b.top, b.left, b.score, b.cls};
  endfunction

endpackage

// ----- rtl/pcbn_front.sv -----
// Input side: takes boxes from the stream and queues them for the back end.
// Depends on pcbn_pkg.
module pcbn_front #(
  parameter int DEPTH = pcbn_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [pcbn_pkg::DATA_W-1:0] s_tdata,  // class, score, left, top, width, height
  input  logic                        s_tlast,
  output logic                        q_valid,
  output pcbn_pkg::item_t             q_item,
  input  logic                        q_pop
);
  import pcbn_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t            mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      fill;
  logic             push;

  assign s_tready = (fill != (PW+1)'(DEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != '0);
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{last: s_tlast, box: unpack_box(s_tdata)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (PW+1)'(push) - (PW+1)'(q_pop);
    end
  end

endmodule

// ----- rtl/pcbn_back.sv -----
// Back end: sorted insertion into the box store, pairwise suppression
// and emission of survivors. Depends on pcbn_pkg.
module pcbn_back #(
  parameter int MAX_BOXES = pcbn_pkg::DEFAULT_MAX_BOXES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [pcbn_pkg::THR_W-1:0]  thr,
  input  logic                        q_valid,
  input  pcbn_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [pcbn_pkg::DATA_W-1:0] m_tdata,
  output logic                        m_tlast,
  output logic                        m_tuser
);
  import pcbn_pkg::*;

  localparam int AW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_BOXES);

  state_t        state, state_next;
  box_t          ent_mem  [MAX_BOXES];
  logic          keep_mem [MAX_BOXES];
  logic [AW-1:0] rd_addr;
  box_t          rd_box;
  logic          rd_keep;
  logic          ent_we;
  logic [AW-1:0] ent_wa;
  box_t          ent_wd;
  logic          keep_we;
  logic [AW-1:0] keep_wa;
  logic          keep_wd;
  logic          out_load;

  item_t         item;
  logic [CW-1:0] count;
  logic          drop_flag;
  logic [AW-1:0] pos;
  logic [CW-1:0] i, j;
  logic [AW-1:0] idx, last_idx;
  box_t          a_box;
  logic [31:0]   area_a, area_b;
  logic [16:0]   iw, ih;
  logic [33:0]   inter;
  logic [32:0]   uni;
  logic [48:0]   prod;

  logic          ahead;
  logic          i_more, j_more;
  logic [16:0]   ra, rb, ba, bb, lo_x, hi_x, lo_y, hi_y, iw_c, ih_c;

  assign ahead  = (rd_box.cls < item.box.cls) ||
                  ((rd_box.cls == item.box.cls) && (rd_box.score >= item.box.score));
  assign i_more = ((i + 1'b1) < count);
  assign j_more = ((j + 1'b1) < count);

  // overlap extents of the held box against the box just read
  always_comb begin
    ra   = {1'b0, a_box.left} + {1'b0, a_box.width};
    rb   = {1'b0, rd_box.left} + {1'b0, rd_box.width};
    ba   = {1'b0, a_box.top} + {1'b0, a_box.height};
    bb   = {1'b0, rd_box.top} + {1'b0, rd_box.height};
    lo_x = (a_box.left > rd_box.left) ? {1'b0, a_box.left} : {1'b0, rd_box.left};
    hi_x = (ra < rb) ? ra : rb;
    lo_y = (a_box.top > rd_box.top) ? {1'b0, a_box.top} : {1'b0, rd_box.top};
    hi_y = (ba < bb) ? ba : bb;
    iw_c = (hi_x > lo_x) ? hi_x - lo_x : '0;
    ih_c = (hi_y > lo_y) ? hi_y - lo_y : '0;
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    rd_box <= ent_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (keep_we) begin
      keep_mem[keep_wa] <= keep_wd;
    end
    rd_keep <= keep_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ent_we     = 1'b0;
    ent_wa     = pos;
    ent_wd     = item.box;
    keep_we    = 1'b0;
    keep_wa    = idx;
    keep_wd    = 1'b1;
    rd_addr    = i[AW-1:0];
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (count == MAXC) begin
          state_next = item.last ? S_INIT : S_IDLE;
        end else if (count == '0) begin
          state_next = S_INS_PUT;
        end else begin
          state_next = S_INS_RD;
        end
      end
      S_INS_RD: begin
        rd_addr    = pos - 1'b1;
        state_next = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (ahead) begin
          state_next = S_INS_PUT;
        end else begin
          // shift the later entry up one place
          ent_we     = 1'b1;
          ent_wd     = rd_box;
          state_next = (pos == AW'(1)) ? S_INS_PUT : S_INS_RD;
        end
      end
      S_INS_PUT: begin
        ent_we     = 1'b1;
        state_next = item.last ? S_INIT : S_IDLE;
      end
      S_INIT: begin
        keep_we = 1'b1;
        if (CW'(idx) == count - 1'b1) begin
          state_next = S_OUT_RD;
        end
      end
      S_OUT_RD: begin
        state_next = S_OUT_CHK;
      end
      S_OUT_CHK: begin
        if (rd_keep && i_more) begin
          state_next = S_IN_RD;
        end else if (i_more) begin
          state_next = S_OUT_RD;
        end else begin
          state_next = S_FIND_RD;
        end
      end
      S_IN_RD: begin
        rd_addr    = j[AW-1:0];
        state_next = S_IN_CHK;
      end
      S_IN_CHK: begin
        if (rd_box.cls != a_box.cls) begin
          state_next = i_more ? S_OUT_RD : S_FIND_RD;
        end else if (!rd_keep) begin
          state_next = j_more ? S_IN_RD : (i_more ? S_OUT_RD : S_FIND_RD);
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: state_next = S_UNI;
      S_UNI: state_next = S_THR;
      S_THR: state_next = S_CMP;
      S_CMP: begin
        keep_we    = ({inter, 16'd0} > {1'b0, prod});
        keep_wa    = j[AW-1:0];
        keep_wd    = 1'b0;
        state_next = j_more ? S_IN_RD : (i_more ? S_OUT_RD : S_FIND_RD);
      end
      S_FIND_RD: begin
        rd_addr    = idx;
        state_next = S_FIND_CHK;
      end
      S_FIND_CHK: begin
        state_next = rd_keep ? S_EM_RD : S_FIND_RD;
      end
      S_EM_RD: begin
        state_next = S_EM_CHK;
      end
      S_EM_CHK: begin
        if (!rd_keep) begin
          state_next = S_EM_RD;
        end else if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = (i[AW-1:0] == last_idx) ? S_IDLE : S_EM_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      drop_flag <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            item <= q_item;
          end
        end
        S_INS_CHK: begin
          if (count == MAXC) begin
            drop_flag <= 1'b1;
          end
          pos <= count[AW-1:0];
          idx <= '0;
        end
        S_INS_CMP: begin
          if (!ahead) begin
            pos <= pos - 1'b1;
          end
        end
        S_INS_PUT: count <= count + 1'b1;
        S_INIT: begin
          idx <= idx + 1'b1;
          i   <= '0;
        end
        S_OUT_RD: idx <= AW'(count - 1'b1);
        S_OUT_CHK: begin
          a_box  <= rd_box;
          area_a <= rd_box.width * rd_box.height;
          j      <= i + 1'b1;
          if (!(rd_keep && i_more)) begin
            i <= i + 1'b1;
          end
        end
        S_IN_CHK: begin
          iw     <= iw_c;
          ih     <= ih_c;
          area_b <= rd_box.width * rd_box.height;
          if (rd_box.cls != a_box.cls) begin
            i <= i + 1'b1;
          end else if (!rd_keep) begin
            j <= j + 1'b1;
            if (!j_more) begin
              i <= i + 1'b1;
            end
          end
        end
        S_MUL: inter <= iw * ih;
        S_UNI: uni <= 33'(area_a) + 33'(area_b) - 33'(inter);
        S_THR: prod <= thr * uni;
        S_CMP: begin
          j <= j + 1'b1;
          if (!j_more) begin
            i <= i + 1'b1;
          end
        end
        S_FIND_CHK: begin
          if (rd_keep) begin
            last_idx <= idx;
            i        <= '0;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        S_EM_CHK: begin
          if (!rd_keep) begin
            i <= i + 1'b1;
          end else if (out_load) begin
            m_tdata  <= pack_box(rd_box);
            m_tlast  <= (i[AW-1:0] == last_idx);
            m_tuser  <= drop_flag;
            i        <= i + 1'b1;
            if (i[AW-1:0] == last_idx) begin
              count     <= '0;
              drop_flag <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/per_class_box_nms.sv -----
// Per-class greedy box suppression. Inserting a box into the sorted store shifts
// later entries up one at a time through the single store port, up to MAX_BOXES-1,
// until an entry stops the shift; a dropped box only sets the overflow flag. After
// the last box: keep flags are set, each kept box is tested against later same-class
// entries, then the store is scanned to emit survivors. Results appear the cycle
// after load; a 4-deep input queue absorbs stalls. Sync reset; threshold 29491.
module per_class_box_nms #(
  parameter int MAX_BOXES = pcbn_pkg::DEFAULT_MAX_BOXES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [pcbn_pkg::THR_W-1:0]  cfg_wr_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [pcbn_pkg::DATA_W-1:0] s_tdata,  // class, score, left, top, width, height
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [pcbn_pkg::DATA_W-1:0] m_tdata,  // class, score, left, top, width, height
  output logic                        m_tlast,
  output logic                        m_tuser   // overflowed
);
  import pcbn_pkg::*;

  logic [THR_W-1:0] thr;
  logic             q_valid;
  item_t            q_item;
  logic             q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  pcbn_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  pcbn_back #(.MAX_BOXES(MAX_BOXES)) u_back (
    .clk(clk), .rst(rst), .thr(thr),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

endmodule

// ----- rtl/pcbn_checker.sv -----
// Port-level checks for per_class_box_nms, bound to the top level.
// Depends on pcbn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcbn_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [pcbn_pkg::DATA_W-1:0] m_tdata,
  input logic                        m_tlast,
  input logic                        m_tuser
);

  // hold a stalled result
  `PCBN_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  // the overflow flag and last marker stay with their stalled request
  `PCBN_ASSERT(a_flags_hold, clk, rst, m_tvalid && !m_tready |=> $stable(m_tuser) && $stable(m_tlast))
  // drop any result on reset
  `PCBN_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !m_tvalid)

endmodule

bind per_class_box_nms pcbn_checker u_pcbn_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tuser(m_tuser)
);

// ----- sim/tb.sv -----
// Testbench for per_class_box_nms: per-class greedy box suppression over batches.
// Depends on pcbn_pkg and the block; predicts the survivors of each batch and
// compares them, in order, with what the block emits.
`timescale 1ns / 100ps

class nms_scoreboard;
  pcbn_pkg::box_t held_box[$];
  logic           held_drop;
  logic [15:0]    thr;
  pcbn_pkg::item_t want_q[$];
  logic            want_ovf[$];
  int              errors;

  function new();
    thr = pcbn_pkg::THRESHOLD_RESET;
    held_drop = 1'b0;
    errors = 0;
  endfunction

  function automatic logic [16:0] span(logic [15:0] a0, logic [15:0] la,
                                       logic [15:0] b0, logic [15:0] lb);
    logic [16:0] hi_a, hi_b, lo, hi;
    hi_a = {1'b0, a0} + {1'b0, la};
    hi_b = {1'b0, b0} + {1'b0, lb};
    lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    hi = (hi_a < hi_b) ? hi_a : hi_b;
    return (hi > lo) ? hi - lo : 17'd0;
  endfunction

  function automatic bit overlaps(pcbn_pkg::box_t a, pcbn_pkg::box_t b);
    logic [63:0] iw, ih, inter, uni;
    iw = 64'(span(a.left, a.width, b.left, b.width));
    ih = 64'(span(a.top, a.height, b.top, b.height));
    inter = iw * ih;
    uni = 64'(a.width) * a.height + 64'(b.width) * b.height - inter;
    return (inter << 16) > 64'(thr) * uni;
  endfunction

  // Note one accepted request; on batch end, suppress and queue survivors.
  function void note_request(pcbn_pkg::box_t b, logic last);
    int pos, lastk;
    bit keep[$];
    pcbn_pkg::item_t it;
    if (held_box.size() < pcbn_pkg::DEFAULT_MAX_BOXES) begin
      pos = 0;
      while (pos < held_box.size() && (held_box[pos].cls < b.cls ||
             (held_box[pos].cls == b.cls && held_box[pos].score >= b.score)))
        pos++;
      held_box.insert(pos, b);
    end else begin
      held_drop = 1'b1;
    end
    if (!last) return;
    foreach (held_box[i]) keep.insert(keep.size(), 1'b1);
    for (int i = 0; i < held_box.size(); i++) begin
      if (!keep[i]) continue;
      for (int j = i + 1; j < held_box.size() && held_box[j].cls == held_box[i].cls; j++)
        if (keep[j] && overlaps(held_box[i], held_box[j])) keep[j] = 1'b0;
    end
    lastk = -1;
    foreach (keep[i]) if (keep[i]) lastk = i;
    foreach (keep[i]) begin
      if (keep[i]) begin
        it.box = held_box[i];
        it.last = (i == lastk);
        want_q.insert(want_q.size(), it);
        want_ovf.insert(want_ovf.size(), held_drop);
      end
    end
    held_box.delete();
    held_drop = 1'b0;
  endfunction

  function void check_survivor(pcbn_pkg::box_t b, logic last, logic ovf);
    pcbn_pkg::item_t w;
    logic wo;
    if (want_q.size() == 0) begin
      $error("unexpected survivor class=%0d", b.cls);
      errors++;
      return;
    end
    w = want_q.pop_front();
    wo = want_ovf.pop_front();
    if (b.cls !== w.box.cls) begin
      $error("out_class exp %0d got %0d", w.box.cls, b.cls); errors++; end
    if (b.score !== w.box.score) begin
      $error("out_score exp %0d got %0d", w.box.score, b.score); errors++; end
    if (b.left !== w.box.left) begin
      $error("out_left exp %0d got %0d", w.box.left, b.left); errors++; end
    if (b.top !== w.box.top) begin
      $error("out_top exp %0d got %0d", w.box.top, b.top); errors++; end
    if (b.width !== w.box.width) begin
      $error("out_width exp %0d got %0d", w.box.width, b.width); errors++; end
    if (b.height !== w.box.height) begin
      $error("out_height exp %0d got %0d", w.box.height, b.height); errors++; end
    if (last !== w.last) begin
      $error("out_last exp %0d got %0d", w.last, last); errors++; end
    if (ovf !== wo) begin
      $error("overflowed exp %0d got %0d", wo, ovf); errors++; end
  endfunction
endclass

module tb;
  import pcbn_pkg::*;

  localparam int WATCHDOG = 200000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [THR_W-1:0]  cfg_wr_data = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic              m_tlast;
  logic              m_tuser;

  nms_scoreboard sb = new();
  int  idle_pct = 25;
  int  quiet_cycles = 0;
  int  total_items = 0;

  per_class_box_nms i_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver side: random stall, check each accepted survivor.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        sb.check_survivor(unpack_box(m_tdata), m_tlast, m_tuser);
      m_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  // Leave tvalid high across back-to-back requests; drop it only while idling.
  task automatic send_box(box_t b, logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= pack_box(b);
    s_tlast  <= last;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(b, last);
    total_items++;
  endtask

  // Hold until every survivor has arrived, then let the block settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_threshold(logic [15:0] v);
    drain();
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.thr = v;
  endtask

  function automatic box_t rand_box(logic [7:0] cls_max, bit wide);
    box_t b;
    b.cls   = 8'($urandom_range(cls_max));
    b.score = ($urandom_range(3) == 0) ? 16'($urandom_range(3) * 1000) : 16'($urandom);
    if (wide) begin
      b.left   = 16'($urandom);
      b.top    = 16'($urandom);
      b.width  = 16'($urandom);
      b.height = 16'($urandom);
    end else begin
      // Clustered boxes so overlaps are common.
      b.left   = 16'(4000 + $urandom_range(600));
      b.top    = 16'(4000 + $urandom_range(600));
      b.width  = 16'(200 + $urandom_range(800));
      b.height = 16'(200 + $urandom_range(800));
    end
    return b;
  endfunction

  task automatic send_batch(int n, logic [7:0] cls_max);
    bit wide;
    wide = ($urandom_range(4) == 0);
    for (int k = 0; k < n; k++) send_box(rand_box(cls_max, wide), k == n - 1);
  endtask

  initial begin
    box_t b;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: duplicates, zero-area pair, extremes, score ties, single box.
    b = '{cls: 8'd3, score: 16'd500, left: 16'd100, top: 16'd100,
          width: 16'd160, height: 16'd160};
    send_box(b, 1'b0);
    b.score = 16'd900; send_box(b, 1'b0);
    b.score = 16'd500; b.left = 16'd101; send_box(b, 1'b0);
    b.cls = 8'd0; b.width = 16'd0; b.height = 16'd0; send_box(b, 1'b0);
    send_box(b, 1'b0);
    b = '{cls: 8'hFF, score: 16'hFFFF, left: 16'hFFFF, top: 16'hFFFF,
          width: 16'hFFFF, height: 16'hFFFF};
    send_box(b, 1'b0);
    send_box(b, 1'b0);
    b = '{cls: 8'h00, score: 16'h0000, left: 16'h0000, top: 16'h0000,
          width: 16'hFFFF, height: 16'hFFFF};
    send_box(b, 1'b0);
    b.left = 16'h8000; b.top = 16'h8000; send_box(b, 1'b1);
    send_box(b, 1'b1);
    set_threshold(16'd0);
    send_batch(6, 8'd1);
    set_threshold(16'hFFFF);
    send_batch(6, 8'd1);
    set_threshold(16'd32768);
    // Overflow: fill past capacity, batch end on a dropped box.
    send_batch(DEFAULT_MAX_BOXES + 3, 8'd3);

    // Random batches, varied threshold, one quiet stretch without idling.
    for (int r = 0; total_items < 430; r++) begin
      if (r % 8 == 7) set_threshold($urandom_range(5) == 0 ? 16'($urandom) : 16'd29491);
      idle_pct = (r >= 10 && r < 16) ? 0 : 25;
      if (r == 20) drain();
      send_batch($urandom_range(12) == 0 ? $urandom_range(40, 66) : $urandom_range(1, 8),
                 $urandom_range(1) ? 8'd2 : 8'd255);
    end
    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
